// File: hw/rtl/pivot_goto_limit_controller_top_assert.svh
// Assertion macros for the pivot and roller drive controller.
// Each macro expects clk and rst to be visible where it is used.
`ifndef PIVOT_GOTO_LIMIT_CONTROLLER_TOP_ASSERT_SVH
`define PIVOT_GOTO_LIMIT_CONTROLLER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PGL_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PGL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pgl_pkg.sv
package pgl_pkg;

  typedef struct packed {
    logic [3:0]         kind;
    logic [11:0]        pot_sample;
    logic               upper_switch;
    logic               lower_switch;
    logic signed [11:0] manual_speed;
    logic signed [11:0] target_angle;
    logic               broken_flag;
    logic [1:0]         roller_direction;
  } in_t;

  typedef struct packed {
    logic signed [11:0] pivot_drive;
    logic signed [11:0] roller_drive;
    logic               at_target;
    logic               pivot_broken_status;
  } out_t;

  typedef struct packed {
    logic [11:0] pot_low_code;
    logic [17:0] span_reciprocal;
    logic [9:0]  goto_deadband;
  } cfg_t;

  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int ANGLE_W    = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_POT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_REC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd2;

  localparam logic [11:0] POT_LOW_RST  = 12'd1147;
  localparam logic [17:0] SPAN_REC_RST = 18'd29891;
  localparam logic [9:0]  DEADBAND_RST = 10'd102;

  localparam logic [3:0] KIND_TICK        = 4'd0;
  localparam logic [3:0] KIND_MANUAL      = 4'd1;
  localparam logic [3:0] KIND_GOTO        = 4'd2;
  localparam logic [3:0] KIND_DRAWBRIDGE  = 4'd3;
  localparam logic [3:0] KIND_STOP_GOTO   = 4'd4;
  localparam logic [3:0] KIND_PIVOT_BROKE = 4'd5;
  localparam logic [3:0] KIND_ROLL_BROKE  = 4'd6;
  localparam logic [3:0] KIND_ROLLER_DIR  = 4'd7;
  localparam logic [3:0] KIND_SOFT_RESET  = 4'd8;

  localparam logic [1:0] ROLLER_IN   = 2'd0;
  localparam logic [1:0] ROLLER_OUT  = 2'd1;
  localparam logic [1:0] ROLLER_STOP = 2'd2;

  // Speeds, 1.0 = 1024.
  localparam logic signed [11:0] SPD_ZERO      = 12'sd0;
  localparam logic signed [11:0] SPD_UNIT      = 12'sd1024;
  localparam logic signed [11:0] SPD_UNIT_NEG  = -12'sd1024;
  localparam logic signed [11:0] SPD_GOTO_DOWN = -12'sd512;
  localparam logic signed [11:0] SPD_GOTO_UP   = 12'sd614;
  localparam logic signed [11:0] SPD_UP_MAX    = 12'sd717;
  localparam logic signed [11:0] SPD_UP_SLOW   = 12'sd333;
  localparam logic signed [11:0] SPD_DN_FAST   = -12'sd768;
  localparam logic signed [11:0] SPD_DN_MID    = -12'sd410;
  localparam logic signed [11:0] SPD_DN_SLOW   = -12'sd102;
  localparam logic signed [11:0] SPD_ROLL_IN   = 12'sd666;
  localparam logic signed [11:0] SPD_ROLL_OUT  = -12'sd819;

  // Angles, 1.0 = top of travel = 1024.
  localparam logic signed [ANGLE_W-1:0] ANG_UPPER_STOP = 15'sd1004;
  localparam logic signed [ANGLE_W-1:0] ANG_UP_ZONE    = 15'sd666;
  localparam logic signed [ANGLE_W-1:0] ANG_HIGH_ZONE  = 15'sd563;
  localparam logic signed [ANGLE_W-1:0] ANG_MID_ZONE   = 15'sd205;
  localparam logic signed [ANGLE_W-1:0] ANG_ZERO       = 15'sd0;
  localparam logic signed [11:0]        ANG_DRAWBRIDGE = 12'sd328;

endpackage

// File: hw/rtl/pgl_cfg_regs.sv
module pgl_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pgl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pgl_pkg::CFG_DATA_W-1:0] cfg_data,
  output pgl_pkg::cfg_t                  cfg
);
  import pgl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pot_low_code    <= POT_LOW_RST;
      cfg.span_reciprocal <= SPAN_REC_RST;
      cfg.goto_deadband   <= DEADBAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POT_LOW:  cfg.pot_low_code    <= cfg_data[11:0];
        CFG_SPAN_REC: cfg.span_reciprocal <= cfg_data[17:0];
        CFG_DEADBAND: cfg.goto_deadband   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/pgl_angle.sv
module pgl_angle (
  input  logic [11:0]                        pot_sample,
  input  pgl_pkg::cfg_t                      cfg,
  output logic signed [pgl_pkg::ANGLE_W-1:0] angle
);
  import pgl_pkg::*;

  logic signed [12:0] diff;
  logic signed [31:0] prod;

  assign diff = $signed({1'b0, pot_sample}) - $signed({1'b0, cfg.pot_low_code});
  assign prod = 32'(diff * $signed({1'b0, cfg.span_reciprocal}));
  // An arithmetic shift rounds towards minus infinity on both signs.
  assign angle = prod[30:16];

endmodule

// File: hw/rtl/pgl_ctrl.sv
module pgl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  pgl_pkg::in_t  item,
  input  pgl_pkg::cfg_t cfg,
  output pgl_pkg::out_t result
);
  import pgl_pkg::*;

  logic               goto_mode, goto_mode_next;
  logic               pivot_fault, pivot_fault_next;
  logic               roller_fault, roller_fault_next;
  logic               arrived, arrived_next;
  logic signed [11:0] desired_speed, desired_speed_next;
  logic signed [11:0] roller_speed, roller_speed_next;
  logic signed [11:0] goal_angle, goal_angle_next;
  logic signed [11:0] applied_pivot, applied_pivot_next;
  logic signed [11:0] applied_roller, applied_roller_next;

  logic signed [ANGLE_W-1:0] angle;
  logic signed [15:0]        angle_wide;
  logic signed [15:0]        band_hi;
  logic signed [15:0]        band_lo;
  logic                      at_up;
  logic                      at_low;
  logic signed [11:0]        tick_speed;
  logic                      tick_arrived;
  logic signed [11:0]        tick_roller;
  logic signed [11:0]        manual_sat;

  pgl_angle u_angle (
    .pot_sample (item.pot_sample),
    .cfg        (cfg),
    .angle      (angle)
  );

  assign angle_wide = 16'(angle);
  assign band_hi    = 16'(goal_angle) + $signed({6'd0, cfg.goto_deadband});
  assign band_lo    = 16'(goal_angle) - $signed({6'd0, cfg.goto_deadband});
  assign at_up      = item.upper_switch || (angle >= ANG_UPPER_STOP);
  assign at_low     = item.lower_switch || (angle <= ANG_ZERO);

  always_comb begin
    tick_speed   = desired_speed;
    tick_arrived = arrived;
    if (goto_mode) begin
      if (angle_wide > band_hi) begin
        tick_speed = SPD_GOTO_DOWN;
      end else if (angle_wide < band_lo) begin
        tick_speed = SPD_GOTO_UP;
      end else begin
        tick_speed   = SPD_ZERO;
        tick_arrived = 1'b1;
      end
    end
    if (tick_speed > SPD_ZERO && at_up) begin
      tick_speed = SPD_ZERO;
    end
    if (tick_speed < SPD_ZERO && at_low) begin
      tick_speed = SPD_ZERO;
    end
    if (!pivot_fault && angle < ANG_UP_ZONE) begin
      if (tick_speed > SPD_UP_MAX) tick_speed = SPD_UP_MAX;
    end else if (tick_speed > SPD_UP_SLOW) begin
      tick_speed = SPD_UP_SLOW;
    end
    if (!pivot_fault) begin
      if (angle > ANG_HIGH_ZONE) begin
        if (tick_speed < SPD_DN_FAST) tick_speed = SPD_DN_FAST;
      end else if (angle > ANG_MID_ZONE) begin
        if (tick_speed < SPD_DN_MID) tick_speed = SPD_DN_MID;
      end else if (tick_speed < SPD_DN_SLOW) begin
        tick_speed = SPD_DN_SLOW;
      end
    end else if (tick_speed < SPD_DN_MID) begin
      tick_speed = SPD_DN_MID;
    end
    tick_roller = roller_speed;
    if (roller_speed > SPD_ZERO && !roller_fault) begin
      tick_roller = SPD_ZERO;
    end
  end

  always_comb begin
    manual_sat = item.manual_speed;
    if (item.manual_speed > SPD_UNIT) begin
      manual_sat = SPD_UNIT;
    end else if (item.manual_speed < SPD_UNIT_NEG) begin
      manual_sat = SPD_UNIT_NEG;
    end
  end

  always_comb begin
    goto_mode_next      = goto_mode;
    pivot_fault_next    = pivot_fault;
    roller_fault_next   = roller_fault;
    arrived_next        = arrived;
    desired_speed_next  = desired_speed;
    roller_speed_next   = roller_speed;
    goal_angle_next     = goal_angle;
    applied_pivot_next  = applied_pivot;
    applied_roller_next = applied_roller;
    if (step) begin
      case (item.kind)
        KIND_TICK: begin
          arrived_next        = tick_arrived;
          desired_speed_next  = tick_speed;
          roller_speed_next   = tick_roller;
          applied_pivot_next  = tick_speed;
          applied_roller_next = tick_roller;
        end
        KIND_MANUAL: begin
          desired_speed_next = manual_sat;
          if (manual_sat != SPD_ZERO) goto_mode_next = 1'b0;
        end
        KIND_GOTO: begin
          goto_mode_next  = 1'b1;
          goal_angle_next = item.target_angle;
          arrived_next    = pivot_fault;
        end
        KIND_DRAWBRIDGE: begin
          goto_mode_next  = 1'b1;
          goal_angle_next = ANG_DRAWBRIDGE;
          arrived_next    = pivot_fault;
        end
        KIND_STOP_GOTO: goto_mode_next = 1'b0;
        KIND_PIVOT_BROKE: begin
          pivot_fault_next = item.broken_flag;
          if (item.broken_flag && goto_mode) begin
            arrived_next       = 1'b1;
            desired_speed_next = SPD_ZERO;
          end
        end
        KIND_ROLL_BROKE: roller_fault_next = item.broken_flag;
        KIND_ROLLER_DIR: begin
          case (item.roller_direction)
            ROLLER_IN:   roller_speed_next = SPD_ROLL_IN;
            ROLLER_OUT:  roller_speed_next = SPD_ROLL_OUT;
            ROLLER_STOP: roller_speed_next = SPD_ZERO;
            default: ;
          endcase
        end
        KIND_SOFT_RESET: begin
          desired_speed_next  = SPD_ZERO;
          roller_speed_next   = SPD_ZERO;
          applied_pivot_next  = SPD_ZERO;
          applied_roller_next = SPD_ZERO;
          goto_mode_next      = 1'b0;
          arrived_next        = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goto_mode      <= 1'b0;
      pivot_fault    <= 1'b0;
      roller_fault   <= 1'b0;
      arrived        <= 1'b0;
      desired_speed  <= SPD_ZERO;
      roller_speed   <= SPD_ZERO;
      goal_angle     <= SPD_ZERO;
      applied_pivot  <= SPD_ZERO;
      applied_roller <= SPD_ZERO;
    end else begin
      goto_mode      <= goto_mode_next;
      pivot_fault    <= pivot_fault_next;
      roller_fault   <= roller_fault_next;
      arrived        <= arrived_next;
      desired_speed  <= desired_speed_next;
      roller_speed   <= roller_speed_next;
      goal_angle     <= goal_angle_next;
      applied_pivot  <= applied_pivot_next;
      applied_roller <= applied_roller_next;
    end
  end

  assign result.pivot_drive         = applied_pivot_next;
  assign result.roller_drive        = applied_roller_next;
  assign result.at_target           = !goto_mode_next || arrived_next;
  assign result.pivot_broken_status = pivot_fault_next;

endmodule

// File: hw/rtl/pivot_goto_limit_controller_top.sv
// Pivot and roller drive controller. Every input beat, command or control tick, yields exactly
// one result beat carrying the applied pivot and roller outputs, the arrival flag and the pivot
// fault flag. A beat is registered on entry, its state update and result are formed from that entry
// register around a single 13 by 19 bit multiply for the pot angle, and the result is registered on
// exit: one beat per cycle sustained while out_stall stays low. Configuration writes take effect at
// the following clock edge.
`include "pivot_goto_limit_controller_top_assert.svh"

module pivot_goto_limit_controller_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pgl_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pgl_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [pgl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pgl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pgl_pkg::*;

  cfg_t  cfg;
  in_t   s1_item;
  logic  s1_valid;
  logic  advance;
  logic  step;
  out_t  result;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign step     = s1_valid && advance;

  pgl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pgl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (step) begin
      out_data <= result;
    end
  end

  `PGL_ASSERT_NEXT(a_held_beat_kept, s1_valid && in_stall, s1_valid, "held input beat was lost")
  `PGL_ASSERT_NEXT(a_step_gives_result, step, out_valid, "processed beat gave no result")
  `PGL_ASSERT_NOW(a_pivot_in_range, out_valid, (out_data.pivot_drive <= SPD_UNIT) && (out_data.pivot_drive >= SPD_UNIT_NEG), "pivot drive out of range")

endmodule
